/* hdl/slip_frame_encoder_assert.svh */
// assertion macros for the slip frame encoder, sampled on clk and held off during rst_n
`ifndef SLIP_FRAME_ENCODER_ASSERT_SVH
`define SLIP_FRAME_ENCODER_ASSERT_SVH

// condition must hold at every clock edge
`define SFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sfe_pkg.sv */
package sfe_pkg;

    localparam int FRAME_LIMIT = 1024;
    localparam int COUNT_W     = $clog2(FRAME_LIMIT + 1);

    localparam logic [7:0] END_CODE     = 8'hC0;
    localparam logic [7:0] ESC_CODE     = 8'hDB;
    localparam logic [7:0] ESC_END_CODE = 8'hDC;
    localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_done;
        logic       frame_abort;
    } result_t;

    // all results one request produces, in emit order
    typedef struct packed {
        logic [1:0]        n;
        result_t [2:0]     res;
    } plan_t;

endpackage

/* hdl/sfe_encode.sv */
module sfe_encode
    import sfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       frame_last,
    output logic       plan_valid,
    output plan_t      plan,
    input  logic       plan_taken
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               plan_valid_reg;
    logic               plan_valid_next;
    plan_t              plan_reg;
    plan_t              plan_next;
    logic               accept;
    logic               room;
    logic               close_end;
    logic [COUNT_W-1:0] count_sum;
    result_t            close_res;

    assign in_ready = !plan_valid_reg || plan_taken;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        plan_next  = '0;
        count_sum  = count_reg;
        room       = !ovf_reg && (count_reg < COUNT_W'(FRAME_LIMIT - 1));
        if (room)
        begin
            if (payload_byte == END_CODE || payload_byte == ESC_CODE)
            begin
                plan_next.res[0] = '{line_byte: ESC_CODE, frame_done: 1'b0, frame_abort: 1'b0};
                plan_next.res[1] = '{line_byte: (payload_byte == END_CODE) ? ESC_END_CODE
                                                                        : ESC_ESC_CODE,
                                     frame_done: 1'b0, frame_abort: 1'b0};
                plan_next.n      = 2'd2;
                count_sum        = count_reg + COUNT_W'(2);
            end
            else
            begin
                plan_next.res[0] = '{line_byte: payload_byte, frame_done: 1'b0,
                                     frame_abort: 1'b0};
                plan_next.n      = 2'd1;
                count_sum        = count_reg + COUNT_W'(1);
            end
        end
        ovf_next   = ovf_reg || !room;
        count_next = count_sum;

        close_end = !ovf_next && (count_sum < COUNT_W'(FRAME_LIMIT));
        close_res = '{line_byte: close_end ? END_CODE : 8'h00, frame_done: 1'b1,
                      frame_abort: !close_end};
        if (frame_last)
        begin
            case (plan_next.n)
                2'd0:    plan_next.res[0] = close_res;
                2'd1:    plan_next.res[1] = close_res;
                default: plan_next.res[2] = close_res;
            endcase
            plan_next.n = plan_next.n + 2'd1;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_comb
    begin
        plan_valid_next = plan_valid_reg;
        if (accept)
            plan_valid_next = 1'b1;
        else if (plan_taken)
            plan_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            plan_reg <= plan_next;
    end

    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

endmodule

/* hdl/sfe_serialize.sv */
module sfe_serialize
    import sfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       plan_valid,
    input  plan_t      plan,
    output logic       plan_taken,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       frame_done,
    output logic       frame_abort,
    output logic       item_last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    logic       last_reg;
    result_t    cur;
    logic       load;
    logic       last_res;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = plan.res[0];
            2'd1:    cur = plan.res[1];
            default: cur = plan.res[2];
        endcase
    end

    assign last_res = (idx_reg == (plan.n - 2'd1));
    assign load     = plan_valid && (plan.n != 2'd0) && (!out_valid_reg || out_ready);
    // a dropped byte leaves an empty plan that retires without output
    assign plan_taken = plan_valid && ((plan.n == 2'd0) || (load && last_res));

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_res ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= cur;
            last_reg <= last_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_byte   = res_reg.line_byte;
    assign frame_done  = res_reg.frame_done;
    assign frame_abort = res_reg.frame_abort;
    assign item_last   = last_reg;

endmodule

/* hdl/slip_frame_encoder.sv */
// SLIP frame encoder: payload bytes enter with a last-of-frame flag and leave as line bytes,
// END and ESC escaped, the frame closed by END, or by an abort result (frame_done and
// frame_abort high, line_byte zero) when the frame outgrew its line-byte limit. The input
// stage computes every result of a request combinationally into a plan register; a single
// output register then sends one line byte per cycle while out_ready is high, so a plain
// byte becomes one line byte, an escaped byte two, and a closing END or abort one more.
// Payload flows at one byte per cycle when nothing needs escaping and out_ready stays high;
// requests pass the plan register, then the output register. item_last marks the last
// result of each request; a byte dropped past the limit yields none unless it closes the frame.
`include "slip_frame_encoder_assert.svh"

module slip_frame_encoder
    import sfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       frame_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       frame_done,
    output logic       frame_abort,
    output logic       item_last
);

    logic  plan_valid;
    plan_t plan;
    logic  plan_taken;

    sfe_encode u_encode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .plan_valid   (plan_valid),
        .plan         (plan),
        .plan_taken   (plan_taken)
    );

    sfe_serialize u_serialize (
        .clk         (clk),
        .rst_n       (rst_n),
        .plan_valid  (plan_valid),
        .plan        (plan),
        .plan_taken  (plan_taken),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_byte   (line_byte),
        .frame_done  (frame_done),
        .frame_abort (frame_abort),
        .item_last   (item_last)
    );

    `SFE_ASSERT_ALWAYS(a_abort_shape,
        !(out_valid && frame_abort) || (frame_done && item_last && line_byte == 8'h00),
        "abort result must close the frame with a zero byte")
    `SFE_ASSERT_ALWAYS(a_done_is_last, !(out_valid && frame_done) || item_last,
        "frame close must be the last result of its request")
    `SFE_ASSERT_NEXT(a_results_back_to_back, out_valid && out_ready && !item_last,
        out_valid, "results of one request must follow without a gap")

endmodule
